// ===== rtl/traffic_light_ped_controller_core_assert.svh =====
// assertion macros for the traffic light controller checker
`ifndef TRAFFIC_LIGHT_PED_CONTROLLER_CORE_ASSERT_SVH
`define TRAFFIC_LIGHT_PED_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TLPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TLPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tlpc_pkg.sv =====
// shared types and constants for the traffic light controller
package tlpc_pkg;

  localparam int DUR_W      = 16;
  localparam int CNT_W      = 8;
  localparam int PHASE_W    = 4;
  localparam int LAMP_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALL_RED,
    REG_CHECK,
    REG_GREEN_CHECKS,
    REG_YELLOW,
    REG_CLEARANCE,
    REG_FLASH_HALF,
    REG_FLASH_COUNT,
    REG_WALK
  } cfg_reg_t;

  localparam logic [PHASE_W-1:0] PH_ALL_RED   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_NS_GREEN  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_NS_YELLOW = 4'd2;
  localparam logic [PHASE_W-1:0] PH_EW_GREEN  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_EW_YELLOW = 4'd4;
  localparam logic [PHASE_W-1:0] PH_EW_FLASH  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WALK_NS   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_NS_FLASH  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_WALK_EW   = 4'd8;

  localparam logic [LAMP_W-1:0] L_RED_NS    = 8'h01;
  localparam logic [LAMP_W-1:0] L_YEL_NS    = 8'h02;
  localparam logic [LAMP_W-1:0] L_GRN_NS    = 8'h04;
  localparam logic [LAMP_W-1:0] L_RED_EW    = 8'h08;
  localparam logic [LAMP_W-1:0] L_YEL_EW    = 8'h10;
  localparam logic [LAMP_W-1:0] L_GRN_EW    = 8'h20;
  localparam logic [LAMP_W-1:0] L_WALK_STOP = 8'h40;
  localparam logic [LAMP_W-1:0] L_WALK_GO   = 8'h80;

  typedef struct packed {
    logic push_ns;
    logic push_ew;
  } item_t;

  typedef struct packed {
    logic               lamp_red_ns;
    logic               lamp_yellow_ns;
    logic               lamp_green_ns;
    logic               lamp_red_ew;
    logic               lamp_yellow_ew;
    logic               lamp_green_ew;
    logic               lamp_walk_stop;
    logic               lamp_walk_go;
    logic [PHASE_W-1:0] phase;
  } result_t;

  typedef struct packed {
    logic [DUR_W-1:0] all_red_ticks;
    logic [DUR_W-1:0] check_ticks;
    logic [CNT_W-1:0] green_checks;
    logic [DUR_W-1:0] yellow_ticks;
    logic [DUR_W-1:0] clearance_ticks;
    logic [DUR_W-1:0] flash_half_ticks;
    logic [CNT_W-1:0] flash_count;
    logic [DUR_W-1:0] walk_ticks;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               sub1;
    logic [CNT_W-1:0]   rep;
    logic [PHASE_W-1:0] saved;
    logic [LAMP_W-1:0]  lamps;
  } ctl_t;

endpackage

// ===== rtl/tlpc_step.sv =====
// next-state and lamp logic for one tick of the controller
module tlpc_step #(
  parameter int TIMER_WIDTH = 16
) (
  input  tlpc_pkg::ctl_t           ctl,
  input  logic [TIMER_WIDTH-1:0]   tick,
  input  tlpc_pkg::cfg_t           cfg,
  input  tlpc_pkg::item_t          item,
  output tlpc_pkg::result_t        result,
  output tlpc_pkg::ctl_t           ctl_next,
  output logic [TIMER_WIDTH-1:0]   tick_next
);
  import tlpc_pkg::*;

  localparam int CW = (TIMER_WIDTH < DUR_W) ? TIMER_WIDTH : DUR_W;

  logic [PHASE_W-1:0]     ph;
  logic [LAMP_W-1:0]      lamp_on;
  logic [LAMP_W-1:0]      lamp_off;
  logic [LAMP_W-1:0]      lamps_a;
  logic [DUR_W-1:0]       dur_sel;
  logic [CW-1:0]          dur_w;
  logic [TIMER_WIDTH-1:0] seg_len;
  logic [TIMER_WIDTH-1:0] tick_inc;
  logic                   seg_end;
  logic [CNT_W-1:0]       rep_inc;
  logic [CNT_W-1:0]       green_min;
  logic [CNT_W-1:0]       flash_min;
  logic [PHASE_W-1:0]     resume_ph;

  assign ph = (ctl.phase > PH_WALK_EW) ? PH_ALL_RED : ctl.phase;

  // lamp changes that open a segment
  always_comb begin
    lamp_on  = '0;
    lamp_off = '0;
    unique case (ph)
      PH_ALL_RED: begin
        lamp_on = L_WALK_STOP | L_RED_NS | L_RED_EW;
      end
      PH_NS_GREEN: begin
        lamp_on  = L_RED_EW | L_GRN_NS;
        lamp_off = L_RED_NS;
      end
      PH_NS_YELLOW: begin
        lamp_on  = L_RED_EW | L_YEL_NS;
        lamp_off = L_GRN_NS;
      end
      PH_EW_GREEN: begin
        lamp_on  = ctl.sub1 ? (L_RED_NS | L_GRN_EW) : L_RED_NS;
        lamp_off = ctl.sub1 ? (L_YEL_NS | L_RED_EW) : L_YEL_NS;
      end
      PH_EW_YELLOW: begin
        lamp_on  = ctl.sub1 ? (L_RED_EW | L_RED_NS) : L_YEL_EW;
        lamp_off = ctl.sub1 ? L_YEL_EW : L_GRN_EW;
      end
      PH_EW_FLASH: begin
        lamp_on  = ctl.sub1 ? '0 : L_YEL_EW;
        lamp_off = ctl.sub1 ? L_YEL_EW : L_GRN_EW;
      end
      PH_NS_FLASH: begin
        lamp_on  = ctl.sub1 ? '0 : L_YEL_NS;
        lamp_off = ctl.sub1 ? L_YEL_NS : L_GRN_NS;
      end
      PH_WALK_NS: begin
        lamp_on  = L_RED_EW | L_WALK_GO;
        lamp_off = L_WALK_STOP;
      end
      default: begin
        lamp_on  = L_RED_NS | L_WALK_GO;
        lamp_off = L_WALK_STOP;
      end
    endcase
  end

  assign lamps_a = (tick == '0) ? ((ctl.lamps | lamp_on) & ~lamp_off) : ctl.lamps;

  assign result.lamp_red_ns    = |(lamps_a & L_RED_NS);
  assign result.lamp_yellow_ns = |(lamps_a & L_YEL_NS);
  assign result.lamp_green_ns  = |(lamps_a & L_GRN_NS);
  assign result.lamp_red_ew    = |(lamps_a & L_RED_EW);
  assign result.lamp_yellow_ew = |(lamps_a & L_YEL_EW);
  assign result.lamp_green_ew  = |(lamps_a & L_GRN_EW);
  assign result.lamp_walk_stop = |(lamps_a & L_WALK_STOP);
  assign result.lamp_walk_go   = |(lamps_a & L_WALK_GO);
  assign result.phase          = ph;

  // segment length
  always_comb begin
    unique case (ph)
      PH_ALL_RED:                dur_sel = cfg.all_red_ticks;
      PH_NS_GREEN:               dur_sel = cfg.check_ticks;
      PH_NS_YELLOW:              dur_sel = cfg.yellow_ticks;
      PH_EW_GREEN:               dur_sel = ctl.sub1 ? cfg.check_ticks : cfg.clearance_ticks;
      PH_EW_YELLOW:              dur_sel = ctl.sub1 ? cfg.clearance_ticks : cfg.yellow_ticks;
      PH_EW_FLASH, PH_NS_FLASH:  dur_sel = cfg.flash_half_ticks;
      default:                   dur_sel = cfg.walk_ticks;
    endcase
  end

  assign dur_w     = dur_sel[CW-1:0];
  assign seg_len   = (dur_w == '0) ? TIMER_WIDTH'(1) : TIMER_WIDTH'(dur_w);
  assign tick_inc  = tick + TIMER_WIDTH'(1);
  assign seg_end   = (tick_inc == '0) || (tick_inc >= seg_len);
  assign rep_inc   = ctl.rep + CNT_W'(1);
  assign green_min = (cfg.green_checks == '0) ? CNT_W'(1) : cfg.green_checks;
  assign flash_min = (cfg.flash_count == '0) ? CNT_W'(1) : cfg.flash_count;
  assign resume_ph = (ctl.saved <= PH_EW_YELLOW) ? ctl.saved : PH_ALL_RED;

  always_comb begin
    ctl_next       = ctl;
    ctl_next.phase = ph;
    ctl_next.lamps = lamps_a;
    tick_next      = tick_inc;
    if (seg_end) begin
      tick_next = '0;
      unique case (ph)
        PH_ALL_RED: begin
          ctl_next.phase = PH_NS_GREEN;
          ctl_next.sub1  = 1'b0;
          ctl_next.rep   = '0;
        end
        PH_NS_YELLOW: begin
          ctl_next.phase = PH_EW_GREEN;
          ctl_next.sub1  = 1'b0;
          ctl_next.rep   = '0;
        end
        PH_NS_GREEN, PH_EW_GREEN: begin
          priority if (ph == PH_EW_GREEN && !ctl.sub1) begin
            ctl_next.sub1 = 1'b1;
          end else if (item.push_ns) begin
            ctl_next.saved = ph;
            ctl_next.phase = (ph == PH_EW_GREEN) ? PH_EW_FLASH : PH_WALK_NS;
            ctl_next.sub1  = 1'b0;
            ctl_next.rep   = '0;
          end else if (item.push_ew) begin
            ctl_next.saved = ph;
            ctl_next.phase = (ph == PH_NS_GREEN) ? PH_NS_FLASH : PH_WALK_EW;
            ctl_next.sub1  = 1'b0;
            ctl_next.rep   = '0;
          end else if (rep_inc >= green_min) begin
            ctl_next.phase = ph + PHASE_W'(1);
            ctl_next.sub1  = 1'b0;
            ctl_next.rep   = '0;
          end else begin
            ctl_next.rep = rep_inc;
          end
        end
        PH_EW_YELLOW: begin
          if (ctl.sub1) begin
            ctl_next.phase = PH_ALL_RED;
            ctl_next.sub1  = 1'b0;
            ctl_next.rep   = '0;
          end else begin
            ctl_next.sub1 = 1'b1;
          end
        end
        PH_EW_FLASH, PH_NS_FLASH: begin
          priority if (!ctl.sub1) begin
            ctl_next.sub1 = 1'b1;
          end else if (rep_inc >= flash_min) begin
            ctl_next.phase = ph + PHASE_W'(1);
            ctl_next.sub1  = 1'b0;
            ctl_next.rep   = '0;
          end else begin
            ctl_next.sub1 = 1'b0;
            ctl_next.rep  = rep_inc;
          end
        end
        PH_WALK_NS: begin
          ctl_next.lamps = (lamps_a | L_WALK_STOP) & ~(L_WALK_GO | L_RED_EW);
          ctl_next.phase = resume_ph;
          ctl_next.sub1  = (resume_ph == PH_EW_GREEN);
          ctl_next.rep   = '0;
        end
        default: begin
          ctl_next.lamps = (lamps_a | L_WALK_STOP) & ~(L_WALK_GO | L_RED_NS);
          ctl_next.phase = resume_ph;
          ctl_next.sub1  = (resume_ph == PH_EW_GREEN);
          ctl_next.rep   = '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/traffic_light_ped_controller_core.sv =====
// top level of the traffic light controller with pedestrian crossing
//
//   channel  | signals                              | role
//   item     | item_valid, item_ready, item         | one base tick with button levels
//   result   | result_valid, result_ready, result   | lamp levels and phase for that tick
//   cfg      | cfg_valid, cfg_ready, cfg_index/data | timing register write
//
// one transaction per cycle sustained while result_ready is high; a result is
// valid once its item transaction has passed the input register and then the
// result register
// the tick logic between the two registers is a single pass, state updates as
// the item moves into the result register
// reset puts the controller in all-red with all lamps off and loads the
// default timings; a stalled result holds and the input register keeps accepting
// until it fills
module traffic_light_ped_controller_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  tlpc_pkg::item_t                      item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output tlpc_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tlpc_pkg::*;

  item_t                  item_q;
  logic                   item_full;
  logic                   advance;
  cfg_t                   cfg;
  ctl_t                   ctl;
  ctl_t                   ctl_next;
  logic [TIMER_WIDTH-1:0] tick;
  logic [TIMER_WIDTH-1:0] tick_next;
  result_t                result_next;

  assign advance    = item_full && (!result_valid || result_ready);
  assign item_ready = !item_full || advance;
  assign cfg_ready  = 1'b1;

  tlpc_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .ctl       (ctl),
    .tick      (tick),
    .cfg       (cfg),
    .item      (item_q),
    .result    (result_next),
    .ctl_next  (ctl_next),
    .tick_next (tick_next)
  );

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
    if (advance) begin
      result <= result_next;
    end
    if (rst) begin
      item_full    <= 1'b0;
      result_valid <= 1'b0;
      ctl          <= '0;
      tick         <= '0;
    end else begin
      if (item_ready) begin
        item_full <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
        ctl          <= ctl_next;
        tick         <= tick_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.all_red_ticks    <= DUR_W'(40);
      cfg.check_ticks      <= DUR_W'(4);
      cfg.green_checks     <= CNT_W'(20);
      cfg.yellow_ticks     <= DUR_W'(12);
      cfg.clearance_ticks  <= DUR_W'(20);
      cfg.flash_half_ticks <= DUR_W'(1);
      cfg.flash_count      <= CNT_W'(20);
      cfg.walk_ticks       <= DUR_W'(60);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALL_RED:      cfg.all_red_ticks    <= cfg_data;
        REG_CHECK:        cfg.check_ticks      <= cfg_data;
        REG_GREEN_CHECKS: cfg.green_checks     <= cfg_data[CNT_W-1:0];
        REG_YELLOW:       cfg.yellow_ticks     <= cfg_data;
        REG_CLEARANCE:    cfg.clearance_ticks  <= cfg_data;
        REG_FLASH_HALF:   cfg.flash_half_ticks <= cfg_data;
        REG_FLASH_COUNT:  cfg.flash_count      <= cfg_data[CNT_W-1:0];
        REG_WALK:         cfg.walk_ticks       <= cfg_data;
        default:          cfg.walk_ticks       <= cfg.walk_ticks;
      endcase
    end
  end

endmodule

// ===== rtl/tlpc_checker.sv =====
// port-level checker for the traffic light controller and its bind
`include "traffic_light_ped_controller_core_assert.svh"

module tlpc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input tlpc_pkg::result_t                    result
);
  import tlpc_pkg::*;

  // stalled result holds
  `TLPC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(result), "stalled result changed")

  // all-red shows both reds and the pedestrian stop lamp
  `TLPC_ASSERT_IMP(a_all_red_lamps, result_valid && result.phase == PH_ALL_RED,
    result.lamp_red_ns && result.lamp_red_ew && result.lamp_walk_stop,
    "all-red phase without red lamps")

  // ns green phase shows ns green, ew red
  `TLPC_ASSERT_IMP(a_ns_green_lamps, result_valid && result.phase == PH_NS_GREEN,
    result.lamp_green_ns && !result.lamp_red_ns && result.lamp_red_ew,
    "ns green phase with wrong lamps")

  // walk phases light walk and not stop
  `TLPC_ASSERT_IMP(a_walk_lamps,
    result_valid && (result.phase == PH_WALK_NS || result.phase == PH_WALK_EW),
    result.lamp_walk_go && !result.lamp_walk_stop,
    "walk phase without walk lamp")

endmodule

bind traffic_light_ped_controller_core tlpc_checker u_tlpc_checker (.*);
